// ----- rtl/chol_pkg.sv -----
package chol_pkg;

    localparam int ElemW = 32;
    localparam int AccW  = 64;
    localparam logic signed [AccW-1:0] AccMax = 64'sh0000_7FFF_FFFF_FFFF;
    localparam logic signed [AccW-1:0] AccMin = -64'sh0000_8000_0000_0000;

    // Operation codes for the shared divide/root unit.
    typedef enum logic {
        OP_SQRT = 1'b0,
        OP_DIV  = 1'b1
    } dr_op_t;

    typedef struct packed {
        logic   start;
        dr_op_t op;
    } dr_ctrl_t;

endpackage

// ----- rtl/chol_divroot.sv -----
// Shared bit-serial unit: a 64-bit restoring divider or integer square root.
// One quotient or root bit per cycle.
module chol_divroot
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  chol_pkg::dr_ctrl_t        ctrl,
    input  logic [63:0]               num,
    input  logic [31:0]               den,
    output logic                      done,
    output logic [63:0]               result
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SQRT,
        S_DIV
    } state_t;

    state_t      state_reg;
    logic [6:0]  count_reg;
    logic [63:0] x_reg;
    logic [63:0] res_reg;
    logic [63:0] bit_reg;
    logic [63:0] rem_reg;
    logic [31:0] den_reg;
    logic        done_reg;

    logic [64:0] rem_shift;
    logic [64:0] rem_sub;
    logic [63:0] trial;

    assign rem_shift = {rem_reg, x_reg[63]};
    assign rem_sub   = rem_shift - {33'd0, den_reg};
    assign trial     = res_reg + bit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (ctrl.start)
                    begin
                        x_reg     <= num;
                        den_reg   <= den;
                        res_reg   <= '0;
                        rem_reg   <= '0;
                        bit_reg   <= 64'd1 << 62;
                        count_reg <= 7'd0;
                        state_reg <= (ctrl.op == chol_pkg::OP_DIV) ? S_DIV : S_SQRT;
                    end
                end
                S_SQRT:
                begin
                    if (x_reg >= trial)
                    begin
                        x_reg   <= x_reg - trial;
                        res_reg <= (res_reg >> 1) + bit_reg;
                    end
                    else
                    begin
                        res_reg <= res_reg >> 1;
                    end
                    bit_reg   <= bit_reg >> 2;
                    count_reg <= count_reg + 7'd1;
                    if (count_reg == 7'd31)
                    begin
                        state_reg <= S_IDLE;
                        done_reg  <= 1'b1;
                    end
                end
                S_DIV:
                begin
                    x_reg <= {x_reg[62:0], 1'b0};
                    if (!rem_sub[64])
                    begin
                        rem_reg <= rem_sub[63:0];
                        res_reg <= {res_reg[62:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_shift[63:0];
                        res_reg <= {res_reg[62:0], 1'b0};
                    end
                    count_reg <= count_reg + 7'd1;
                    if (count_reg == 7'd63)
                    begin
                        state_reg <= S_IDLE;
                        done_reg  <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

// ----- rtl/cholesky_factorization_core.sv -----
// Channel   | Direction | Signals                                    | Handshake
// ----------+-----------+--------------------------------------------+--------------------------
// request   | in        | start, matrix_element                      | start & !busy
// result    | out       | result_valid, factor_element, last_of_run, | one cycle strobe
//           |           | not_positive_definite                      |
// config    | in        | cfg_we, cfg_wdata                          | cfg_we, no wait
//
// A load request is taken whenever busy is low; the request that completes the
// matrix starts the factorization, and busy stays high through it and the output.
// An entry in column j is sequenced and multiply-accumulated over its j products,
// then waits on the shared bit-serial unit to divide or, on the diagonal, take a root.
// Output reads and emits each entry in turn, one strobe per entry, n*n in all.
// Reset is asynchronous and active low. The receiver cannot stall results.
module cholesky_factorization_core
#(
    parameter int MAX_ORDER = 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] matrix_element,
    input  logic               cfg_we,
    input  logic [3:0]         cfg_wdata,
    output logic               result_valid,
    output logic signed [31:0] factor_element,
    output logic               last_of_run,
    output logic               not_positive_definite
);

    localparam int Depth = MAX_ORDER * MAX_ORDER;
    localparam int AW    = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int IW    = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
    localparam int CW    = IW + 1;

    typedef enum logic [3:0] {
        S_LOAD,
        S_COL,
        S_ACC_INIT,
        S_MAC_RD,
        S_MAC_MUL,
        S_MAC_ACC,
        S_DR_START,
        S_DR_WAIT,
        S_NEXT,
        S_OUT_RD,
        S_OUT_EMIT
    } state_t;

    // The input matrix lives in a; the factor is written back over it.
    logic [31:0] a_mem [Depth];
    logic [31:0] rd_data_reg;
    logic [31:0] rd2_data_reg;

    state_t      state_reg;
    logic [3:0]  size_reg;
    logic [6:0]  load_count_reg;
    logic [CW-1:0] n_reg;
    logic [CW-1:0] i_reg, j_reg, k_reg;
    logic signed [63:0] acc_reg;
    logic signed [63:0] prod_reg;
    logic [31:0] diag_reg;
    logic        fail_reg;
    logic        neg_reg;
    logic [AW:0] out_idx_reg;
    logic        valid_reg;
    logic signed [31:0] fe_reg;
    logic        last_reg;

    chol_pkg::dr_ctrl_t dr_ctrl;
    logic [63:0] dr_num;
    logic        dr_done;
    logic [63:0] dr_result;

    logic [CW-1:0] n_eff;
    logic [7:0]    total;
    logic [AW-1:0] addr_ij, addr_ik, addr_jk, addr_jj;
    logic signed [64:0] acc_diff;
    logic [63:0] acc_abs;
    logic signed [64:0] q_signed;
    logic signed [31:0] q_sat;
    logic signed [63:0] elem_ext;

    always_comb
    begin
        if (size_reg == 4'd0)
            n_eff = CW'(1);
        else if (32'(size_reg) > MAX_ORDER)
            n_eff = CW'(MAX_ORDER);
        else
            n_eff = CW'(size_reg);
    end

    assign total   = 8'(n_eff) * 8'(n_eff);
    assign addr_ij = AW'(32'(i_reg) * 32'(n_reg) + 32'(j_reg));
    assign addr_ik = AW'(32'(i_reg) * 32'(n_reg) + 32'(k_reg));
    assign addr_jk = AW'(32'(j_reg) * 32'(n_reg) + 32'(k_reg));
    assign addr_jj = AW'(32'(j_reg) * 32'(n_reg) + 32'(j_reg));

    assign acc_diff = 65'(acc_reg) - 65'(prod_reg);
    assign acc_abs  = acc_reg[63] ? 64'(-acc_reg) : 64'(acc_reg);
    assign q_signed = neg_reg ? -$signed({1'b0, dr_result}) : $signed({1'b0, dr_result});
    assign q_sat    = (q_signed > 65'sd2147483647) ? 32'sh7FFF_FFFF :
                      (q_signed < -65'sd2147483648) ? 32'sh8000_0000 : q_signed[31:0];
    assign elem_ext = 64'($signed(rd_data_reg)) <<< 16;

    // A diagonal that is not positive never starts the shared unit, so it is
    // idle when the next factorization needs it.
    assign dr_ctrl.start = (state_reg == S_DR_START) &&
                           !((i_reg == j_reg) && (acc_reg <= 64'sd0));
    assign dr_ctrl.op    = (i_reg == j_reg) ? chol_pkg::OP_SQRT : chol_pkg::OP_DIV;
    assign dr_num        = (i_reg == j_reg) ? 64'(acc_reg) : acc_abs;

    chol_divroot u_divroot
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (dr_ctrl),
        .num    (dr_num),
        .den    (diag_reg),
        .done   (dr_done),
        .result (dr_result)
    );

    // Memory: one write port, two registered read ports.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_LOAD && start)
            a_mem[AW'(load_count_reg)] <= matrix_element;
        else if (state_reg == S_DR_WAIT && dr_done)
            a_mem[addr_ij] <= (i_reg == j_reg) ? dr_result[31:0] : q_sat;
        else if (state_reg == S_NEXT && fail_reg)
            a_mem[addr_ij] <= '0;

        case (state_reg)
            S_ACC_INIT:  rd_data_reg <= a_mem[addr_ij];
            S_MAC_RD:
            begin
                rd_data_reg  <= a_mem[addr_ik];
                rd2_data_reg <= a_mem[addr_jk];
            end
            S_OUT_RD:    rd_data_reg <= a_mem[out_idx_reg[AW-1:0]];
            default:     rd2_data_reg <= a_mem[addr_jj];
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_LOAD;
            size_reg       <= 4'd8;
            load_count_reg <= '0;
            fail_reg       <= 1'b0;
            valid_reg      <= 1'b0;
            last_reg       <= 1'b0;
            n_reg          <= '0;
            i_reg          <= '0;
            j_reg          <= '0;
            k_reg          <= '0;
            out_idx_reg    <= '0;
        end
        else
        begin
            valid_reg <= 1'b0;
            last_reg  <= 1'b0;
            if (cfg_we)
                size_reg <= cfg_wdata;
            case (state_reg)
                S_LOAD:
                begin
                    if (start)
                    begin
                        if (8'(load_count_reg) + 8'd1 >= total)
                        begin
                            load_count_reg <= '0;
                            n_reg          <= n_eff;
                            fail_reg       <= 1'b0;
                            j_reg          <= '0;
                            i_reg          <= '0;
                            state_reg      <= S_COL;
                        end
                        else
                        begin
                            load_count_reg <= load_count_reg + 7'd1;
                        end
                    end
                end
                S_COL:
                begin
                    // i_reg selects the entry in column j_reg being worked on.
                    k_reg     <= '0;
                    state_reg <= fail_reg ? S_NEXT : S_ACC_INIT;
                end
                S_ACC_INIT:
                begin
                    state_reg <= S_MAC_RD;
                end
                S_MAC_RD:
                begin
                    if (k_reg == '0)
                        acc_reg <= elem_ext;
                    state_reg <= (k_reg == j_reg) ? S_DR_START : S_MAC_MUL;
                end
                S_MAC_MUL:
                begin
                    prod_reg  <= 64'($signed(rd_data_reg)) * 64'($signed(rd2_data_reg));
                    state_reg <= S_MAC_ACC;
                end
                S_MAC_ACC:
                begin
                    if (acc_diff > 65'(chol_pkg::AccMax))
                        acc_reg <= chol_pkg::AccMax;
                    else if (acc_diff < 65'(chol_pkg::AccMin))
                        acc_reg <= chol_pkg::AccMin;
                    else
                        acc_reg <= acc_diff[63:0];
                    k_reg     <= k_reg + CW'(1);
                    state_reg <= S_MAC_RD;
                end
                S_DR_START:
                begin
                    if (i_reg == j_reg)
                    begin
                        if (acc_reg <= 64'sd0)
                        begin
                            fail_reg  <= 1'b1;
                            state_reg <= S_NEXT;
                        end
                        else
                            state_reg <= S_DR_WAIT;
                    end
                    else
                    begin
                        neg_reg   <= acc_reg[63];
                        state_reg <= S_DR_WAIT;
                    end
                end
                S_DR_WAIT:
                begin
                    if (dr_done)
                    begin
                        if (i_reg == j_reg)
                            diag_reg <= dr_result[31:0];
                        state_reg <= S_NEXT;
                    end
                end
                S_NEXT:
                begin
                    if (i_reg + CW'(1) < n_reg)
                    begin
                        i_reg     <= i_reg + CW'(1);
                        state_reg <= S_COL;
                    end
                    else if (j_reg + CW'(1) < n_reg)
                    begin
                        j_reg     <= j_reg + CW'(1);
                        i_reg     <= j_reg + CW'(1);
                        state_reg <= S_COL;
                    end
                    else
                    begin
                        out_idx_reg <= '0;
                        i_reg       <= '0;
                        j_reg       <= '0;
                        state_reg   <= S_OUT_RD;
                    end
                end
                S_OUT_RD:
                begin
                    state_reg <= S_OUT_EMIT;
                end
                S_OUT_EMIT:
                begin
                    valid_reg <= 1'b1;
                    fe_reg    <= (j_reg > i_reg) ? '0 : $signed(rd_data_reg);
                    last_reg  <= (32'(out_idx_reg) + 1 == 32'(n_reg) * 32'(n_reg));
                    if (32'(out_idx_reg) + 1 == 32'(n_reg) * 32'(n_reg))
                        state_reg <= S_LOAD;
                    else
                    begin
                        state_reg   <= S_OUT_RD;
                        out_idx_reg <= out_idx_reg + (AW+1)'(1);
                        if (j_reg + CW'(1) == n_reg)
                        begin
                            j_reg <= '0;
                            i_reg <= i_reg + CW'(1);
                        end
                        else
                            j_reg <= j_reg + CW'(1);
                    end
                end
                default:
                begin
                    state_reg <= S_LOAD;
                end
            endcase
        end
    end

    assign busy                  = (state_reg != S_LOAD);
    assign result_valid          = valid_reg;
    assign factor_element        = fe_reg;
    assign last_of_run           = last_reg;
    assign not_positive_definite = fail_reg;

endmodule

// ----- tb/sv/cholesky_factorization_core_tb.sv -----
`timescale 1ns / 1ps

module cholesky_factorization_core_tb;

    // Limit on the whole run in clock cycles. The slowest correct run is
    // far below this, even with long request gaps and full size matrices.
    localparam int CycleLimit = 600000;
    // Cycles to let pass after the last expected factor entry before a
    // size write or the end of the run.
    localparam int SettleCycles = 40;
    localparam int RandomItems = 170;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic signed [31:0] matrix_element;
    logic               cfg_we;
    logic [3:0]         cfg_wdata;
    logic               result_valid;
    logic signed [31:0] factor_element;
    logic               last_of_run;
    logic               not_positive_definite;

    cholesky_factorization_core #(
        .MAX_ORDER(8)
    ) dut (
        .clk                  (clk),
        .rst_n                (rst_n),
        .start                (start),
        .busy                 (busy),
        .matrix_element       (matrix_element),
        .cfg_we               (cfg_we),
        .cfg_wdata            (cfg_wdata),
        .result_valid         (result_valid),
        .factor_element       (factor_element),
        .last_of_run          (last_of_run),
        .not_positive_definite(not_positive_definite)
    );

    // One expected entry of the factor L.
    typedef struct {
        logic signed [31:0] value;
        logic               last;
        logic               npd;
    } factor_entry_t;

    // A row of the directed table: either a size write or one request.
    // Where has_exp is set, the run is of order one and its single factor
    // entry is known at a glance.
    typedef struct {
        bit                 is_cfg;
        logic [31:0]        data;
        bit                 has_exp;
        logic signed [31:0] exp_value;
        bit                 exp_npd;
    } directed_row_t;

    factor_entry_t factor_queue[$];
    // The final entry of the most recent predicted factorization.
    factor_entry_t last_predicted;

    // The shadow copy of the block's state.
    logic [31:0] shadow_store[64];
    logic [6:0]  shadow_count;
    logic [3:0]  shadow_size;

    int mismatches;
    int requests_sent;
    int entries_checked;
    int runs_done;
    int npd_runs;
    longint cycle_count;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
        mismatches++;
    endtask

    // Floor of the integer square root of a 64-bit unsigned value.
    function automatic logic [63:0] root_floor(input logic [63:0] x);
        logic [63:0] res;
        logic [63:0] bitv;
        res = 64'd0;
        bitv = 64'd1 << 62;
        while (bitv > x)
        begin
            bitv = bitv >> 2;
        end
        while (bitv != 0)
        begin
            if (x >= res + bitv)
            begin
                x = x - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
            begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic longint clamp_acc(input longint v);
        if (v > longint'(chol_pkg::AccMax)) return longint'(chol_pkg::AccMax);
        if (v < longint'(chol_pkg::AccMin)) return longint'(chol_pkg::AccMin);
        return v;
    endfunction

    function automatic int order_of(input logic [3:0] sz);
        if (sz == 4'd0) return 1;
        if (sz > 4'd8) return 8;
        return int'(sz);
    endfunction

    // Store one accepted element. When it completes the matrix, factor it
    // column by column and queue all n*n entries of L in row-major order.
    task automatic load_and_factor(input logic [31:0] elem);
        longint fac[8][8];
        longint acc;
        longint diag;
        longint q;
        int n;
        bit failed;
        factor_entry_t fe;
        n = order_of(shadow_size);
        shadow_store[shadow_count[5:0]] = elem;
        shadow_count = shadow_count + 7'd1;
        if (int'(shadow_count) < n * n) return;
        failed = 1'b0;
        for (int a = 0; a < 8; a++)
        begin
            for (int b = 0; b < 8; b++)
            begin
                fac[a][b] = 0;
            end
        end
        for (int j = 0; j < n; j++)
        begin
            acc = longint'($signed(shadow_store[(j * n + j) % 64])) * 65536;
            diag = 0;
            for (int k = 0; k < j; k++)
            begin
                acc = clamp_acc(acc - fac[j][k] * fac[j][k]);
            end
            // A diagonal argument that is not positive zeroes this entry
            // and every entry computed after it.
            if (failed || acc <= 0)
            begin
                failed = 1'b1;
            end
            else
            begin
                diag = longint'(root_floor(64'(acc)));
                fac[j][j] = diag;
            end
            for (int i = j + 1; i < n; i++)
            begin
                if (!failed)
                begin
                    acc = longint'($signed(shadow_store[(i * n + j) % 64])) * 65536;
                    for (int k = 0; k < j; k++)
                    begin
                        acc = clamp_acc(acc - fac[i][k] * fac[j][k]);
                    end
                    q = acc / diag;
                    if (q > 64'sd2147483647) q = 64'sd2147483647;
                    if (q < -64'sd2147483648) q = -64'sd2147483648;
                    fac[i][j] = q;
                end
            end
        end
        for (int i = 0; i < n; i++)
        begin
            for (int j = 0; j < n; j++)
            begin
                fe.value = fac[i][j][31:0];
                fe.last = (i == n - 1) && (j == n - 1);
                fe.npd = failed;
                factor_queue.push_back(fe);
            end
        end
        last_predicted = fe;
        runs_done++;
        if (failed) npd_runs++;
        shadow_count = 7'd0;
    endtask

    // Wait until every expected entry has come out and the block is idle.
    task automatic wait_idle();
        while (factor_queue.size() != 0 || busy)
        begin
            @(posedge clk);
        end
        repeat (SettleCycles) @(posedge clk);
    endtask

    // A size write while no factorization runs; a load in progress keeps
    // its count.
    task automatic write_size(input logic [3:0] sz);
        @(negedge clk);
        start = 1'b0;
        wait_idle();
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_wdata = sz;
        @(posedge clk);
        shadow_size = sz;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // Drive one request and hold it until the block accepts it. The gap
    // that follows is random: mostly none or short, now and then long.
    task automatic send_element(input logic [31:0] elem);
        int gap;
        @(negedge clk);
        start = 1'b1;
        matrix_element = elem;
        do
        begin
            @(posedge clk);
        end
        while (busy);
        load_and_factor(elem);
        requests_sent++;
        case ($urandom_range(9))
            0, 1, 2, 3, 4: gap = 0;
            5, 6, 7: gap = $urandom_range(3, 1);
            8: gap = $urandom_range(8, 4);
            default: gap = $urandom_range(60, 20);
        endcase
        if (gap > 0)
        begin
            @(negedge clk);
            start = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // Result side: every strobe is compared with the oldest expectation.
    always @(posedge clk)
    begin
        factor_entry_t fe;
        if (rst_n && result_valid)
        begin
            if (factor_queue.size() == 0)
            begin
                report_mismatch($sformatf("unexpected factor entry %h",
                                          factor_element));
            end
            else
            begin
                fe = factor_queue.pop_front();
                entries_checked++;
                if (factor_element !== fe.value)
                    report_mismatch($sformatf("factor_element %h, expected %h",
                                              factor_element, fe.value));
                if (last_of_run !== fe.last)
                    report_mismatch($sformatf("last_of_run %b, expected %b",
                                              last_of_run, fe.last));
                if (not_positive_definite !== fe.npd)
                    report_mismatch($sformatf("not_positive_definite %b, expected %b",
                                              not_positive_definite, fe.npd));
            end
        end
    end

    // Watchdog: a hung block ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CycleLimit)
        begin
            $display("timeout with %0d entries still expected", factor_queue.size());
            $display("cholesky_factorization_core regression: fail");
            $finish;
        end
    end

    // The directed part: order-one matrices with values read off directly,
    // the zero and out-of-range encodings of the size, a diagonal that
    // fails, and a size lowered in the middle of a load.
    directed_row_t directed_rows[] = '{
        '{1'b1, 32'd1,         1'b0, 32'sd0,       1'b0},
        '{1'b0, 32'h0001_0000, 1'b1, 32'h0001_0000, 1'b0},
        '{1'b0, 32'h0000_0000, 1'b1, 32'sd0,       1'b1},
        '{1'b0, 32'h8000_0000, 1'b1, 32'sd0,       1'b1},
        '{1'b0, 32'h7FFF_FFFF, 1'b0, 32'sd0,       1'b0},
        '{1'b0, 32'h0000_0001, 1'b0, 32'sd0,       1'b0},
        '{1'b0, 32'hFFFF_FFFF, 1'b1, 32'sd0,       1'b1},
        '{1'b1, 32'd0,         1'b0, 32'sd0,       1'b0},
        '{1'b0, 32'h0004_0000, 1'b1, 32'h0002_0000, 1'b0},
        '{1'b1, 32'd2,         1'b0, 32'sd0,       1'b0},
        '{1'b0, 32'h0004_0000, 1'b0, 32'sd0,       1'b0},
        '{1'b0, 32'h7FFF_FFFF, 1'b0, 32'sd0,       1'b0},
        '{1'b0, 32'h8000_0000, 1'b0, 32'sd0,       1'b0},
        '{1'b0, 32'h0000_0001, 1'b0, 32'sd0,       1'b0},
        '{1'b1, 32'd3,         1'b0, 32'sd0,       1'b0},
        '{1'b0, 32'h0001_0000, 1'b0, 32'sd0,       1'b0},
        '{1'b0, 32'h0002_0000, 1'b0, 32'sd0,       1'b0},
        '{1'b0, 32'h0003_0000, 1'b0, 32'sd0,       1'b0},
        '{1'b0, 32'h0002_0000, 1'b0, 32'sd0,       1'b0},
        '{1'b0, 32'hFFFF_0000, 1'b0, 32'sd0,       1'b0},
        '{1'b1, 32'd2,         1'b0, 32'sd0,       1'b0},
        '{1'b0, 32'h1234_5678, 1'b0, 32'sd0,       1'b0},
        '{1'b1, 32'd15,        1'b0, 32'sd0,       1'b0}
    };

    initial
    begin
        logic [31:0] mat[8][8];
        int n;
        int pick;
        int sz_code;
        logic [31:0] off;
        factor_entry_t fe;
        bit first_random;

        rst_n = 1'b0;
        start = 1'b0;
        matrix_element = '0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        mismatches = 0;
        requests_sent = 0;
        entries_checked = 0;
        runs_done = 0;
        npd_runs = 0;
        cycle_count = 0;
        shadow_count = 7'd0;
        shadow_size = 4'd8;
        for (int i = 0; i < 64; i++)
        begin
            shadow_store[i] = 32'd0;
        end

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(posedge clk);

        foreach (directed_rows[r])
        begin
            if (directed_rows[r].is_cfg)
            begin
                write_size(directed_rows[r].data[3:0]);
            end
            else
            begin
                send_element(directed_rows[r].data);
                // An order-one run has exactly one entry, the last predicted.
                if (directed_rows[r].has_exp)
                begin
                    fe = last_predicted;
                    if (fe.value !== directed_rows[r].exp_value ||
                        fe.npd !== directed_rows[r].exp_npd || !fe.last)
                        report_mismatch($sformatf("directed row %0d predicts %h/%b",
                                                  r, fe.value, fe.npd));
                end
            end
        end

        // Random part: whole matrices, mostly positive definite with random
        // content, the rest raw noise or made to fail on one diagonal.
        // The first run uses the full order of eight.
        first_random = 1'b1;
        while (requests_sent < RandomItems)
        begin
            pick = $urandom_range(99);
            if (first_random) sz_code = 8;
            else if (pick < 70) sz_code = $urandom_range(4, 1);
            else if (pick < 85) sz_code = $urandom_range(7, 5);
            else if (pick < 90) sz_code = 8;
            else if (pick < 95) sz_code = 0;
            else sz_code = $urandom_range(15, 9);
            first_random = 1'b0;
            write_size(4'(sz_code));
            n = order_of(4'(sz_code));

            pick = $urandom_range(99);
            for (int i = 0; i < n; i++)
            begin
                for (int j = 0; j <= i; j++)
                begin
                    if (i == j)
                    begin
                        mat[i][j] = (n << 20) + $urandom_range(32'h40_0000);
                    end
                    else
                    begin
                        off = $urandom_range(32'h20_0000);
                        mat[i][j] = off - 32'h10_0000;
                    end
                    if (pick >= 75 && pick < 88) mat[i][j] = $urandom;
                end
                // Entries above the diagonal are ignored; fill them freely.
                for (int j = i + 1; j < n; j++)
                begin
                    mat[i][j] = $urandom;
                end
            end
            if (pick >= 88)
            begin
                sz_code = $urandom_range(n - 1);
                mat[sz_code][sz_code] = ($urandom_range(1) == 0) ? 32'd0 : -$urandom_range(32'h40_0000);
            end
            for (int i = 0; i < n; i++)
            begin
                for (int j = 0; j < n; j++)
                begin
                    send_element(mat[i][j]);
                end
            end
        end

        @(negedge clk);
        start = 1'b0;
        wait_idle();

        $display("Sent %0d requests over %0d factorizations (%0d not positive definite),",
                 requests_sent, runs_done, npd_runs);
        $display("checked %0d factor entries, %0d mismatches.", entries_checked, mismatches);
        if (mismatches == 0 && factor_queue.size() == 0)
        begin
            $display("cholesky_factorization_core regression: pass");
        end
        else
        begin
            $display("cholesky_factorization_core regression: fail");
        end
        $finish;
    end

endmodule
